/* rtl/albp_pkg.sv */
// Shared types and constants for the absolute loader block parser.
// Used by the front, queue, back and top-level modules.
package albp_pkg;

  localparam int unsigned ADDR_BITS   = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  localparam logic [15:0] HDR_LEN    = 16'd6;
  localparam logic [16:0] BLK_SIZE   = 17'd512;
  localparam logic [16:0] SIZE_MAX17 = 17'd131071;
  localparam logic [17:0] BLK_ROUND  = 18'd511;
  localparam int unsigned BLK_SHIFT  = 9;

  localparam logic [7:0] MARK0_VAL = 8'd1;
  localparam logic [7:0] MARK1_VAL = 8'd0;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CHECK = 2'd1,
    KIND_END   = 2'd2,
    KIND_HERR  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    OP_SUM  = 3'd0,
    OP_HERR = 3'd1,
    OP_ALO  = 3'd2,
    OP_AHI  = 3'd3,
    OP_END  = 3'd4,
    OP_DATA = 3'd5,
    OP_CSUM = 3'd6
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] value;
  } op_t;

endpackage

/* rtl/albp_front.sv */
// Front end: tracks the header/data/checksum phase and classifies each byte.
// Depends on albp_pkg for the op type.
module albp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic [7:0]     in_byte_i,
  output albp_pkg::op_t  op_o
);

  typedef enum logic [2:0] {
    PH_MARK0,
    PH_MARK1,
    PH_CNTLO,
    PH_CNTHI,
    PH_ADRLO,
    PH_ADRHI,
    PH_DATA,
    PH_CSUM
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  cnt_lo_q, cnt_lo_d;
  logic [15:0] count_q, count_d;
  logic [15:0] left_q, left_d;
  logic [15:0] count_full;
  logic [15:0] left_dec;

  assign count_full = {in_byte_i, cnt_lo_q};
  assign left_dec   = left_q - 16'd1;

  always_comb begin
    phase_d  = phase_q;
    cnt_lo_d = cnt_lo_q;
    count_d  = count_q;
    left_d   = left_q;
    op_o.op    = albp_pkg::OP_SUM;
    op_o.value = in_byte_i;
    case (phase_q)
      PH_MARK0: begin
        if (in_byte_i != albp_pkg::MARK0_VAL) begin
          op_o.op = albp_pkg::OP_HERR;
        end else begin
          phase_d = PH_MARK1;
        end
      end
      PH_MARK1: begin
        if (in_byte_i != albp_pkg::MARK1_VAL) begin
          op_o.op = albp_pkg::OP_HERR;
          phase_d = PH_MARK0;
        end else begin
          phase_d = PH_CNTLO;
        end
      end
      PH_CNTLO: begin
        cnt_lo_d = in_byte_i;
        phase_d  = PH_CNTHI;
      end
      PH_CNTHI: begin
        count_d = count_full;
        if (count_full < albp_pkg::HDR_LEN) begin
          op_o.op = albp_pkg::OP_HERR;
          phase_d = PH_MARK0;
        end else begin
          phase_d = PH_ADRLO;
        end
      end
      PH_ADRLO: begin
        op_o.op = albp_pkg::OP_ALO;
        phase_d = PH_ADRHI;
      end
      PH_ADRHI: begin
        if (count_q == albp_pkg::HDR_LEN) begin
          op_o.op = albp_pkg::OP_END;
          phase_d = PH_MARK0;
        end else begin
          op_o.op = albp_pkg::OP_AHI;
          left_d  = count_q - albp_pkg::HDR_LEN;
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        op_o.op = albp_pkg::OP_DATA;
        left_d  = left_dec;
        if (left_dec == 16'd0) begin
          phase_d = PH_CSUM;
        end
      end
      PH_CSUM: begin
        op_o.op = albp_pkg::OP_CSUM;
        phase_d = PH_MARK0;
      end
      default: begin
        phase_d = PH_MARK0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MARK0;
      cnt_lo_q <= '0;
      count_q  <= '0;
      left_q   <= '0;
    end else if (push_i) begin
      phase_q  <= phase_d;
      cnt_lo_q <= cnt_lo_d;
      count_q  <= count_d;
      left_q   <= left_d;
    end
  end

endmodule

/* rtl/albp_queue.sv */
// Two-entry op queue between the front and back ends.
// Depends on albp_pkg for the op type and depth constants.
module albp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  albp_pkg::op_t  push_op_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output albp_pkg::op_t  head_op_o
);

  albp_pkg::op_t                 mem_q [albp_pkg::QUEUE_DEPTH];
  logic [albp_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [albp_pkg::QCNT_W-1:0]   cnt_q;

  assign full_o    = (cnt_q == albp_pkg::QCNT_W'(albp_pkg::QUEUE_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign head_op_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/albp_back.sv */
// Back end: executes queued ops, keeps address, checksum and image size,
// and holds the output register. Depends on albp_pkg.
module albp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  albp_pkg::op_t  op_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     kind_o,
  output logic [15:0]    address_o,
  output logic [7:0]     data_o,
  output logic           checksum_ok_o,
  output logic [16:0]    image_size_o,
  output logic [8:0]     block_total_o
);

  logic [albp_pkg::ADDR_BITS-1:0] addr_q, addr_d;
  logic [7:0]  alo_q, alo_d;
  logic [7:0]  sum_q, sum_d;
  logic [16:0] total_q, total_d;
  logic        vld_q, vld_d;
  logic [1:0]  kind_q, kind_d;
  logic [15:0] oaddr_q, oaddr_d;
  logic [7:0]  data_q, data_d;
  logic        ok_q, ok_d;
  logic [16:0] size_q, size_d;
  logic [8:0]  blk_q, blk_d;

  logic [7:0]                     sum_add;
  logic [albp_pkg::ADDR_BITS-1:0] hdr_addr;
  logic [17:0]                    blk_sum;
  logic                           emit;

  assign pop_o    = !empty_i && (!vld_q || out_ready_i);
  assign sum_add  = sum_q + op_i.value;
  assign hdr_addr = albp_pkg::ADDR_BITS'({op_i.value, alo_q});
  assign blk_sum  = {1'b0, total_q} + albp_pkg::BLK_ROUND;

  always_comb begin
    addr_d  = addr_q;
    alo_d   = alo_q;
    sum_d   = sum_q;
    total_d = total_q;
    emit    = 1'b0;
    kind_d  = kind_q;
    oaddr_d = oaddr_q;
    data_d  = data_q;
    ok_d    = ok_q;
    size_d  = size_q;
    blk_d   = blk_q;
    if (pop_o) begin
      kind_d  = albp_pkg::KIND_HERR;
      oaddr_d = '0;
      data_d  = '0;
      ok_d    = 1'b0;
      size_d  = '0;
      blk_d   = '0;
      case (op_i.op)
        albp_pkg::OP_SUM: begin
          sum_d = sum_add;
        end
        albp_pkg::OP_HERR: begin
          sum_d = '0;
          emit  = 1'b1;
        end
        albp_pkg::OP_ALO: begin
          alo_d = op_i.value;
          sum_d = sum_add;
        end
        albp_pkg::OP_AHI: begin
          addr_d = hdr_addr;
          sum_d  = sum_add;
        end
        albp_pkg::OP_END: begin
          addr_d  = hdr_addr;
          sum_d   = '0;
          total_d = albp_pkg::BLK_SIZE;
          emit    = 1'b1;
          kind_d  = albp_pkg::KIND_END;
          oaddr_d = 16'(hdr_addr);
          size_d  = total_q;
          blk_d   = blk_sum[albp_pkg::BLK_SHIFT +: 9];
        end
        albp_pkg::OP_DATA: begin
          addr_d = addr_q + 1'b1;
          sum_d  = sum_add;
          if (total_q < albp_pkg::SIZE_MAX17) begin
            total_d = total_q + 17'd1;
          end
          emit    = 1'b1;
          kind_d  = albp_pkg::KIND_DATA;
          oaddr_d = 16'(addr_q);
          data_d  = op_i.value;
        end
        albp_pkg::OP_CSUM: begin
          sum_d  = '0;
          emit   = 1'b1;
          kind_d = albp_pkg::KIND_CHECK;
          ok_d   = (sum_add == 8'd0);
        end
        default: begin
          sum_d = '0;
        end
      endcase
    end
    if (emit) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end else begin
      vld_d = vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q  <= '0;
      sum_q   <= '0;
      total_q <= albp_pkg::BLK_SIZE;
      vld_q   <= 1'b0;
    end else begin
      addr_q  <= addr_d;
      sum_q   <= sum_d;
      total_q <= total_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    alo_q <= alo_d;
    if (emit) begin
      kind_q  <= kind_d;
      oaddr_q <= oaddr_d;
      data_q  <= data_d;
      ok_q    <= ok_d;
      size_q  <= size_d;
      blk_q   <= blk_d;
    end
  end

  assign out_valid_o   = vld_q;
  assign kind_o        = kind_q;
  assign address_o     = oaddr_q;
  assign data_o        = data_q;
  assign checksum_ok_o = ok_q;
  assign image_size_o  = size_q;
  assign block_total_o = blk_q;

endmodule

/* rtl/absolute_loader_block_parser.sv */
// Absolute loader format parser: one stream byte per item, at most one result.
// Accepted bytes are written to the queue; results are held in the back-end output register.
// Throughput: one byte per cycle while the queue is not full; the two-entry
// queue and the back-end output register let input and output stall independently.
// Reset: asynchronous, active low; waits for a header marker, image size 512.
// Depends on albp_pkg, albp_front, albp_queue and albp_back.
module absolute_loader_block_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [15:0] address_o,
  output logic [7:0]  data_o,
  output logic        checksum_ok_o,
  output logic [16:0] image_size_o,
  output logic [8:0]  block_total_o
);

  albp_pkg::op_t front_op;
  albp_pkg::op_t head_op;
  logic          push;
  logic          full;
  logic          empty;
  logic          pop;

  assign in_ready_o = !full;
  assign push       = in_valid_i && !full;

  albp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_byte_i (in_byte_i),
    .op_o      (front_op)
  );

  albp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (front_op),
    .full_o    (full),
    .pop_i     (pop),
    .empty_o   (empty),
    .head_op_o (head_op)
  );

  albp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .op_i          (head_op),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .address_o     (address_o),
    .data_o        (data_o),
    .checksum_ok_o (checksum_ok_o),
    .image_size_o  (image_size_o),
    .block_total_o (block_total_o)
  );

endmodule
